FILE: design/xxh32_pkg.sv
// Package: xxHash32 primes, sequencer state type and rotate helper.
package xxh32_pkg;

    localparam logic [31:0] PRIME1 = 32'd2654435761;
    localparam logic [31:0] PRIME2 = 32'd2246822519;
    localparam logic [31:0] PRIME3 = 32'd3266489917;
    localparam logic [31:0] PRIME4 = 32'd668265263;
    localparam logic [31:0] PRIME5 = 32'd374761393;

    localparam int unsigned STRIPE_BYTES = 15 + 1;
    localparam int unsigned LANES        = STRIPE_BYTES / 4;
    localparam logic [2:0]  WORD_BYTES   = 3'd4;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_LANE_A = 12'b0000_0000_0010,
        S_LANE_B = 12'b0000_0000_0100,
        S_FIN    = 12'b0000_0000_1000,
        S_FOLD   = 12'b0000_0001_0000,
        S_WORD_A = 12'b0000_0010_0000,
        S_WORD_B = 12'b0000_0100_0000,
        S_BYTE_A = 12'b0000_1000_0000,
        S_BYTE_B = 12'b0001_0000_0000,
        S_AVAL_A = 12'b0010_0000_0000,
        S_AVAL_B = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    // Rotate left by a constant amount between 1 and 31
    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
        logic [31:0] res;
        res = (v << r) | (v >> (32 - r));
        return res;
    endfunction

endpackage

FILE: design/xxhash32_stream_hasher_top.sv
// Top level: xxHash32 stream hasher around one shared 32x32 multiplier.
//
//  channel   signals                                   direction  handshake
//  --------  ----------------------------------------  ---------  ----------------
//  input     data_word, word_bytes, last_item          in         in_valid/in_ready
//  result    hash_value                                out        out_valid/out_ready
//  config    seed_wr_data                              in         seed_wr_en
//
// A non-last word is buffered unless it completes a 16-byte stripe, which runs
// two multiplier passes for each of the four lanes. The last word then adds the
// finish step, the lane fold (when a stripe was seen), two passes per leftover
// word, two per leftover byte, two avalanche passes and the hand-over, all on the
// shared multiplier. in_ready is high only while the sequencer is idle.
// rst_n clears the sequencer, message counters and seed; the result register
// holds its word until out_ready, while the next message is already accepted.
module xxhash32_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_wr_en,
    input  logic [31:0] seed_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  word_bytes,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    xxh32_pkg::state_t state_reg;

    logic [31:0] seed_reg;
    logic [31:0] lane_acc_reg [xxh32_pkg::LANES];
    logic [31:0] word_buffer_reg [3];
    logic [1:0]  buffered_words_reg;
    logic [31:0] byte_total_reg;
    logic        stripe_seen_reg;
    logic        last_pend_reg;
    logic [31:0] word_reg;
    logic [1:0]  nb_reg;
    logic [1:0]  cnt_reg;
    logic [31:0] prod_reg;
    logic [31:0] h_reg;
    logic        out_valid_reg;
    logic [31:0] hash_reg;

    logic        accept;
    logic [2:0]  nb_clamp;
    logic [31:0] lane_word;
    logic [31:0] lane_cur;
    logic [31:0] buf_word;
    logic [7:0]  cur_byte;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_res;
    logic        out_free;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == xxh32_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign hash_value = hash_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Clamp the byte count of the last word to four
    assign nb_clamp = (word_bytes > xxh32_pkg::WORD_BYTES) ? xxh32_pkg::WORD_BYTES : word_bytes;

    // Select the operands seen by the sequencer step
    always_comb
    begin
        case (cnt_reg)
            2'd0:    buf_word = word_buffer_reg[0];
            2'd1:    buf_word = word_buffer_reg[1];
            2'd2:    buf_word = word_buffer_reg[2];
            default: buf_word = word_reg;
        endcase
        lane_word = buf_word;
        lane_cur  = lane_acc_reg[cnt_reg];
        case (cnt_reg)
            2'd0:    cur_byte = word_reg[7:0];
            2'd1:    cur_byte = word_reg[15:8];
            2'd2:    cur_byte = word_reg[23:16];
            default: cur_byte = word_reg[31:24];
        endcase
    end

    // Drive the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            xxh32_pkg::S_LANE_A:
            begin
                mul_a = lane_word;
                mul_b = xxh32_pkg::PRIME2;
            end
            xxh32_pkg::S_LANE_B:
            begin
                mul_a = xxh32_pkg::rotl32(lane_cur + prod_reg, 13);
                mul_b = xxh32_pkg::PRIME1;
            end
            xxh32_pkg::S_WORD_A:
            begin
                mul_a = buf_word;
                mul_b = xxh32_pkg::PRIME3;
            end
            xxh32_pkg::S_WORD_B:
            begin
                mul_a = xxh32_pkg::rotl32(h_reg + prod_reg, 17);
                mul_b = xxh32_pkg::PRIME4;
            end
            xxh32_pkg::S_BYTE_A:
            begin
                mul_a = {24'd0, cur_byte};
                mul_b = xxh32_pkg::PRIME5;
            end
            xxh32_pkg::S_BYTE_B:
            begin
                mul_a = xxh32_pkg::rotl32(h_reg + prod_reg, 11);
                mul_b = xxh32_pkg::PRIME1;
            end
            xxh32_pkg::S_AVAL_A:
            begin
                mul_a = h_reg ^ (h_reg >> 15);
                mul_b = xxh32_pkg::PRIME2;
            end
            xxh32_pkg::S_AVAL_B:
            begin
                mul_a = h_reg ^ (h_reg >> 13);
                mul_b = xxh32_pkg::PRIME3;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res = mul_a * mul_b;

    // Hold the seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_wr_en)
        begin
            seed_reg <= seed_wr_data;
        end
    end

    // Raise the result flag at hand-over, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == xxh32_pkg::S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Sequencer and message control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= xxh32_pkg::S_IDLE;
            buffered_words_reg <= '0;
            byte_total_reg     <= '0;
            stripe_seen_reg    <= 1'b0;
            last_pend_reg      <= 1'b0;
            cnt_reg            <= '0;
        end
        else
        begin
            case (state_reg)
                xxh32_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg       <= '0;
                        last_pend_reg <= last_item;
                        if (!last_item)
                        begin
                            byte_total_reg <= byte_total_reg + 32'd4;
                            if (buffered_words_reg == 2'd3)
                            begin
                                state_reg <= xxh32_pkg::S_LANE_A;
                            end
                            else
                            begin
                                buffered_words_reg <= buffered_words_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            byte_total_reg <= byte_total_reg + {29'd0, nb_clamp};
                            if (nb_clamp == xxh32_pkg::WORD_BYTES)
                            begin
                                if (buffered_words_reg == 2'd3)
                                begin
                                    state_reg <= xxh32_pkg::S_LANE_A;
                                end
                                else
                                begin
                                    buffered_words_reg <= buffered_words_reg + 2'd1;
                                    state_reg          <= xxh32_pkg::S_FIN;
                                end
                            end
                            else
                            begin
                                state_reg <= xxh32_pkg::S_FIN;
                            end
                        end
                    end
                end
                xxh32_pkg::S_LANE_A:
                begin
                    state_reg <= xxh32_pkg::S_LANE_B;
                end
                xxh32_pkg::S_LANE_B:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        buffered_words_reg <= '0;
                        stripe_seen_reg    <= 1'b1;
                        state_reg <= last_pend_reg ? xxh32_pkg::S_FIN : xxh32_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_reg <= xxh32_pkg::S_LANE_A;
                    end
                end
                xxh32_pkg::S_FIN:
                begin
                    cnt_reg <= '0;
                    if (stripe_seen_reg)
                    begin
                        state_reg <= xxh32_pkg::S_FOLD;
                    end
                    else if (buffered_words_reg != 2'd0)
                    begin
                        state_reg <= xxh32_pkg::S_WORD_A;
                    end
                    else if (nb_reg != 2'd0)
                    begin
                        state_reg <= xxh32_pkg::S_BYTE_A;
                    end
                    else
                    begin
                        state_reg <= xxh32_pkg::S_AVAL_A;
                    end
                end
                xxh32_pkg::S_FOLD:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        if (buffered_words_reg != 2'd0)
                        begin
                            state_reg <= xxh32_pkg::S_WORD_A;
                        end
                        else if (nb_reg != 2'd0)
                        begin
                            state_reg <= xxh32_pkg::S_BYTE_A;
                        end
                        else
                        begin
                            state_reg <= xxh32_pkg::S_AVAL_A;
                        end
                    end
                end
                xxh32_pkg::S_WORD_A:
                begin
                    state_reg <= xxh32_pkg::S_WORD_B;
                end
                xxh32_pkg::S_WORD_B:
                begin
                    if (cnt_reg == buffered_words_reg - 2'd1)
                    begin
                        cnt_reg <= '0;
                        state_reg <= (nb_reg != 2'd0) ? xxh32_pkg::S_BYTE_A
                                                      : xxh32_pkg::S_AVAL_A;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 2'd1;
                        state_reg <= xxh32_pkg::S_WORD_A;
                    end
                end
                xxh32_pkg::S_BYTE_A:
                begin
                    state_reg <= xxh32_pkg::S_BYTE_B;
                end
                xxh32_pkg::S_BYTE_B:
                begin
                    if (cnt_reg == nb_reg - 2'd1)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= xxh32_pkg::S_AVAL_A;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 2'd1;
                        state_reg <= xxh32_pkg::S_BYTE_A;
                    end
                end
                xxh32_pkg::S_AVAL_A:
                begin
                    state_reg <= xxh32_pkg::S_AVAL_B;
                end
                xxh32_pkg::S_AVAL_B:
                begin
                    state_reg <= xxh32_pkg::S_DONE;
                end
                xxh32_pkg::S_DONE:
                begin
                    // Hand over the hash and restart the message
                    if (out_free)
                    begin
                        buffered_words_reg <= '0;
                        byte_total_reg     <= '0;
                        stripe_seen_reg    <= 1'b0;
                        last_pend_reg      <= 1'b0;
                        state_reg          <= xxh32_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= xxh32_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers: buffer, lanes, product and running hash
    always_ff @(posedge clk)
    begin
        case (state_reg)
            xxh32_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    word_reg <= data_word;
                    nb_reg   <= (nb_clamp == xxh32_pkg::WORD_BYTES) ? 2'd0 : nb_clamp[1:0];
                    if (buffered_words_reg != 2'd3
                        && (!last_item || nb_clamp == xxh32_pkg::WORD_BYTES))
                    begin
                        word_buffer_reg[buffered_words_reg] <= data_word;
                    end
                    // Load the lanes from the seed at the first stripe
                    if (buffered_words_reg == 2'd3 && !stripe_seen_reg
                        && (!last_item || nb_clamp == xxh32_pkg::WORD_BYTES))
                    begin
                        lane_acc_reg[0] <= seed_reg + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2;
                        lane_acc_reg[1] <= seed_reg + xxh32_pkg::PRIME2;
                        lane_acc_reg[2] <= seed_reg;
                        lane_acc_reg[3] <= seed_reg - xxh32_pkg::PRIME1;
                    end
                end
            end
            xxh32_pkg::S_LANE_A, xxh32_pkg::S_WORD_A, xxh32_pkg::S_BYTE_A:
            begin
                prod_reg <= mul_res;
            end
            xxh32_pkg::S_LANE_B:
            begin
                lane_acc_reg[cnt_reg] <= mul_res;
            end
            xxh32_pkg::S_FIN:
            begin
                h_reg <= (stripe_seen_reg ? 32'd0 : seed_reg + xxh32_pkg::PRIME5)
                         + byte_total_reg;
            end
            xxh32_pkg::S_FOLD:
            begin
                case (cnt_reg)
                    2'd0:    h_reg <= h_reg + xxh32_pkg::rotl32(lane_cur, 1);
                    2'd1:    h_reg <= h_reg + xxh32_pkg::rotl32(lane_cur, 7);
                    2'd2:    h_reg <= h_reg + xxh32_pkg::rotl32(lane_cur, 12);
                    default: h_reg <= h_reg + xxh32_pkg::rotl32(lane_cur, 18);
                endcase
            end
            xxh32_pkg::S_WORD_B, xxh32_pkg::S_BYTE_B,
            xxh32_pkg::S_AVAL_A, xxh32_pkg::S_AVAL_B:
            begin
                h_reg <= mul_res;
            end
            xxh32_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    hash_reg <= h_reg ^ (h_reg >> 16);
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // Closing the fourth lane round marks the stripe as absorbed
    a_stripe_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xxh32_pkg::S_LANE_B && cnt_reg == 2'd3) |=> stripe_seen_reg)
        else $error("stripe not marked after last lane round");

    // Leftover word mixing never runs past the buffered count
    a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xxh32_pkg::S_WORD_A) |-> (cnt_reg < buffered_words_reg))
        else $error("word mix index beyond buffered words");

    // Leftover byte mixing never runs past the loose byte count
    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xxh32_pkg::S_BYTE_A) |-> (cnt_reg < nb_reg))
        else $error("byte mix index beyond loose bytes");

    // Handing over a hash restarts the message state
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xxh32_pkg::S_DONE && out_free)
        |=> (out_valid_reg && buffered_words_reg == 2'd0 && !stripe_seen_reg
             && byte_total_reg == 32'd0))
        else $error("message state not cleared at hash hand-over");

endmodule
